>>> design/ps2mct_pkg.sv
`timescale 1ns / 1ps

package ps2mct_pkg;

    // Field widths shared by the tracker and its checker.
    localparam int BYTE_W   = 8;
    localparam int BTN_W    = 3;
    localparam int DX_W     = 9;
    localparam int DY_W     = 10;
    localparam int COORD_W  = 12;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Protocol bytes and masks of the three-byte packet.
    localparam logic [BYTE_W-1:0] ACK_BYTE   = 8'hFA;
    localparam logic [BYTE_W-1:0] SYNC_MASK  = 8'hC8;
    localparam logic [BYTE_W-1:0] SYNC_VALUE = 8'h08;
    localparam int                XSIGN_BIT  = 4;
    localparam int                YSIGN_BIT  = 5;

    // Cursor size and start position.
    localparam logic [3:0]         CURSOR_W = 4'd8;
    localparam logic [3:0]         CURSOR_H = 4'd4;
    localparam logic [COORD_W-1:0] START_X  = 12'd16;
    localparam logic [COORD_W-1:0] START_Y  = 12'd100;

    // Register reset values.
    localparam logic [COORD_W-1:0] WIDTH_RST  = 12'd320;
    localparam logic [COORD_W-1:0] HEIGHT_RST = 12'd200;

    // Register indexes on the configuration port.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

endpackage

>>> design/ps2_mouse_packet_cursor_tracker.sv
`timescale 1ns / 1ps

// PS/2 mouse packet decoder with a clamped cursor.
// Input channel: one raw mouse byte per request on i_mouse_byte, handshake
// i_in_valid / o_in_ready. Output channel: one result per byte, handshake
// o_out_valid / i_out_ready, with the packet fields and the cursor position.
// The result of a byte accepted by the block is registered and shown in the
// cycle after it is accepted. Throughput is one byte per cycle while the
// receiver takes each result; the single output register is refilled at the
// same edge at which its result is taken. While the receiver stalls, the
// result is held and o_in_ready stays low until the output register is taken.
// After reset the block waits for the 0xFA acknowledge, every byte before it
// yields a result with device_ready low; the cursor starts at (16,100) and the
// screen is 320 by 200. The APB port holds screen width at address 0 and screen
// height at address 4; the user must write it only while idle; the block does not enforce it.
module ps2_mouse_packet_cursor_tracker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [ps2mct_pkg::BYTE_W-1:0]           i_mouse_byte,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic                                    o_packet_done,
    output logic                                    o_device_ready,
    output logic [ps2mct_pkg::BTN_W-1:0]            o_buttons,
    output logic signed [ps2mct_pkg::DX_W-1:0]      o_delta_x,
    output logic signed [ps2mct_pkg::DY_W-1:0]      o_delta_y,
    output logic [ps2mct_pkg::COORD_W-1:0]          o_cursor_x,
    output logic [ps2mct_pkg::COORD_W-1:0]          o_cursor_y,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [ps2mct_pkg::PADDR_W-1:0]          paddr,
    input  logic [ps2mct_pkg::PDATA_W-1:0]          pwdata,
    output logic [ps2mct_pkg::PDATA_W-1:0]          prdata,
    output logic                                    pready
);
    import ps2mct_pkg::*;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_THIRD
    } t_phase;

    // Moves a coordinate and saturates it to 0..size-margin.
    function automatic logic [COORD_W-1:0] f_clamp(
        input logic [COORD_W-1:0] pos,
        input logic [DY_W-1:0]    delta,
        input logic [COORD_W-1:0] size,
        input logic [3:0]         margin
    );
        logic signed [COORD_W+1:0] upper;
        logic signed [COORD_W+1:0] sum;
        logic [COORD_W-1:0]        res;
        upper = $signed({2'b00, size}) - $signed({{(COORD_W-2){1'b0}}, margin});
        if (upper < 0) begin
            upper = '0;
        end
        sum = $signed({2'b00, pos}) + $signed({{(COORD_W+2-DY_W){delta[DY_W-1]}}, delta});
        if (sum < 0) begin
            res = '0;
        end else if (sum > upper) begin
            res = upper[COORD_W-1:0];
        end else begin
            res = sum[COORD_W-1:0];
        end
        return res;
    endfunction

    logic [COORD_W-1:0] r_width;
    logic [COORD_W-1:0] r_height;
    logic               r_await;
    t_phase             r_phase;
    logic [BYTE_W-1:0]  r_first;
    logic [BYTE_W-1:0]  r_second;
    logic [COORD_W-1:0] r_cx;
    logic [COORD_W-1:0] r_cy;
    logic               r_out_valid;
    logic               r_done;
    logic [BTN_W-1:0]   r_btn;
    logic [DX_W-1:0]    r_dx;
    logic [DY_W-1:0]    r_dy;

    logic               n_await;
    t_phase             n_phase;
    logic [BYTE_W-1:0]  n_first;
    logic [BYTE_W-1:0]  n_second;
    logic [COORD_W-1:0] n_cx;
    logic [COORD_W-1:0] n_cy;
    logic               n_done;
    logic [BTN_W-1:0]   n_btn;
    logic [DX_W-1:0]    n_dx;
    logic [DY_W-1:0]    n_dy;

    logic               w_in_acc;
    logic               w_cfg_wr;
    logic [DX_W-1:0]    w_dx;
    logic [DX_W-1:0]    w_dy_raw;
    logic [DY_W-1:0]    w_dy;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    // Register read-back.
    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_WIDTH:  prdata[COORD_W-1:0] = r_width;
            REG_HEIGHT: prdata[COORD_W-1:0] = r_height;
            default:    prdata = '0;
        endcase
    end

    // Packet fields of the current third byte, dy negated for screen direction.
    assign w_dx     = {r_first[XSIGN_BIT], r_second};
    assign w_dy_raw = {r_first[YSIGN_BIT], i_mouse_byte};
    assign w_dy     = DY_W'(0) - {w_dy_raw[DX_W-1], w_dy_raw};

    // Per-byte update of the packet state and the cursor.
    always_comb begin
        n_await  = r_await;
        n_phase  = r_phase;
        n_first  = r_first;
        n_second = r_second;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_done   = 1'b0;
        n_btn    = '0;
        n_dx     = '0;
        n_dy     = '0;
        if (r_await) begin
            if (i_mouse_byte == ACK_BYTE) begin
                n_await = 1'b0;
            end
        end else begin
            case (r_phase)
                PH_SECOND: begin
                    n_second = i_mouse_byte;
                    n_phase  = PH_THIRD;
                end
                PH_THIRD: begin
                    n_done  = 1'b1;
                    n_btn   = r_first[BTN_W-1:0];
                    n_dx    = w_dx;
                    n_dy    = w_dy;
                    n_phase = PH_FIRST;
                    n_cx    = f_clamp(r_cx, {w_dx[DX_W-1], w_dx}, r_width, CURSOR_W);
                    n_cy    = f_clamp(r_cy, w_dy, r_height, CURSOR_H);
                end
                default: begin
                    if ((i_mouse_byte & SYNC_MASK) == SYNC_VALUE) begin
                        n_first = i_mouse_byte;
                        n_phase = PH_SECOND;
                    end else begin
                        n_phase = PH_FIRST;
                    end
                end
            endcase
        end
    end

    // State, configuration and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WIDTH_RST;
            r_height    <= HEIGHT_RST;
            r_await     <= 1'b1;
            r_phase     <= PH_FIRST;
            r_cx        <= START_X;
            r_cy        <= START_Y;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (paddr[2])
                    REG_WIDTH:  r_width  <= pwdata[COORD_W-1:0];
                    REG_HEIGHT: r_height <= pwdata[COORD_W-1:0];
                    default:    r_width  <= r_width;
                endcase
            end
            if (w_in_acc) begin
                r_await     <= n_await;
                r_phase     <= n_phase;
                r_cx        <= n_cx;
                r_cy        <= n_cy;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_done   <= n_done;
            r_btn    <= n_btn;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_packet_done  = r_done;
    assign o_device_ready = !r_await;
    assign o_buttons      = r_btn;
    assign o_delta_x      = $signed(r_dx);
    assign o_delta_y      = $signed(r_dy);
    assign o_cursor_x     = r_cx;
    assign o_cursor_y     = r_cy;

endmodule

>>> design/ps2mct_checker.sv
`timescale 1ns / 1ps

module ps2mct_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    input  logic                                    o_in_ready,
    input  logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    input  logic                                    o_packet_done,
    input  logic                                    o_device_ready,
    input  logic [ps2mct_pkg::BTN_W-1:0]            o_buttons,
    input  logic signed [ps2mct_pkg::DX_W-1:0]      o_delta_x,
    input  logic signed [ps2mct_pkg::DY_W-1:0]      o_delta_y,
    input  logic [ps2mct_pkg::COORD_W-1:0]          o_cursor_x
);
    import ps2mct_pkg::*;

    // A stalled result stays valid and keeps its cursor x position.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_cursor_x))
        else $error("stalled result changed");

    // Every accepted request gives a result in the next cycle.
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted request gave no result");

    // A byte that completes no packet carries zero packet fields.
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_packet_done |->
            o_buttons == '0 && o_delta_x == '0 && o_delta_y == '0)
        else $error("packet fields set without a packet");

    // A packet only completes after the acknowledge.
    a_done_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_done |-> o_device_ready)
        else $error("packet before acknowledge");

endmodule

bind ps2_mouse_packet_cursor_tracker ps2mct_checker u_ps2mct_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_packet_done  (o_packet_done),
    .o_device_ready (o_device_ready),
    .o_buttons      (o_buttons),
    .o_delta_x      (o_delta_x),
    .o_delta_y      (o_delta_y),
    .o_cursor_x     (o_cursor_x)
);

>>> dv/ps2_mouse_packet_cursor_tracker_test.sv
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_tracker_test;

    import ps2mct_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS = 160;

    typedef logic [BYTE_W-1:0] byte_q_t[$];

    // One decoded result as the block presents it.
    typedef struct {
        logic                      done;
        logic                      dev_ready;
        logic [BTN_W-1:0]          btn;
        logic signed [DX_W-1:0]    dx;
        logic signed [DY_W-1:0]    dy;
        logic [COORD_W-1:0]        cx;
        logic [COORD_W-1:0]        cy;
    } tracker_result_t;

    typedef enum int {RX_STREAM, RX_RANDOM, RX_SLOW} rx_mode_e;

    // Tracks the decoder state and the cursor, and holds the expected results.
    class tracker_scoreboard;
        bit                 waiting_ack;
        logic [1:0]         pkt_phase;
        logic [BYTE_W-1:0]  first_b;
        logic [BYTE_W-1:0]  second_b;
        logic [COORD_W-1:0] cur_x;
        logic [COORD_W-1:0] cur_y;
        logic [COORD_W-1:0] scr_w;
        logic [COORD_W-1:0] scr_h;
        tracker_result_t    expected_q[$];
        int                 n_fail;

        function new();
            waiting_ack = 1'b1;
            pkt_phase = 2'd0;
            first_b = '0;
            second_b = '0;
            cur_x = START_X;
            cur_y = START_Y;
            scr_w = WIDTH_RST;
            scr_h = HEIGHT_RST;
            n_fail = 0;
        endfunction

        function void set_screen(logic idx, logic [COORD_W-1:0] value);
            if (idx == REG_WIDTH) begin
                scr_w = value;
            end else begin
                scr_h = value;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Moves one coordinate and saturates it to the visible area.
        function logic [COORD_W-1:0] clamp_move(int pos, int delta, int size, int margin);
            int upper;
            int p;
            upper = size - margin;
            p = pos + delta;
            if (upper < 0) upper = 0;
            if (p < 0) p = 0;
            if (p > upper) p = upper;
            return p[COORD_W-1:0];
        endfunction

        // Advances the decoder by one accepted request and queues its result.
        function void note_byte(logic [BYTE_W-1:0] b);
            tracker_result_t r;
            int dxi;
            int dyi;
            r.done = 1'b0;
            r.btn = '0;
            r.dx = '0;
            r.dy = '0;
            if (waiting_ack) begin
                if (b == ACK_BYTE) waiting_ack = 1'b0;
            end else if (pkt_phase == 2'd1) begin
                second_b = b;
                pkt_phase = 2'd2;
            end else if (pkt_phase == 2'd2) begin
                dxi = first_b[XSIGN_BIT] ? int'(second_b) - 256 : int'(second_b);
                dyi = first_b[YSIGN_BIT] ? int'(b) - 256 : int'(b);
                dyi = -dyi;
                r.done = 1'b1;
                r.btn = first_b[BTN_W-1:0];
                r.dx = dxi[DX_W-1:0];
                r.dy = dyi[DY_W-1:0];
                cur_x = clamp_move(int'(cur_x), dxi, int'(scr_w), int'(CURSOR_W));
                cur_y = clamp_move(int'(cur_y), dyi, int'(scr_h), int'(CURSOR_H));
                pkt_phase = 2'd0;
            end else begin
                // A first byte must carry the sync pattern or it is dropped.
                if ((b & SYNC_MASK) == SYNC_VALUE) begin
                    first_b = b;
                    pkt_phase = 2'd1;
                end else begin
                    pkt_phase = 2'd0;
                end
            end
            r.dev_ready = !waiting_ack;
            r.cx = cur_x;
            r.cy = cur_y;
            expected_q.push_back(r);
        endfunction

        function void cmp_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                n_fail++;
            end
        endfunction

        // Compares one delivered result with the oldest expectation.
        function void check_result(tracker_result_t got);
            tracker_result_t want;
            if (expected_q.size() == 0) begin
                $error("result delivered with no request outstanding");
                n_fail++;
                return;
            end
            want = expected_q.pop_front();
            cmp_field("packet_done", 32'(want.done), 32'(got.done));
            cmp_field("device_ready", 32'(want.dev_ready), 32'(got.dev_ready));
            cmp_field("buttons", 32'(want.btn), 32'(got.btn));
            cmp_field("delta_x", 32'(want.dx), 32'(got.dx));
            cmp_field("delta_y", 32'(want.dy), 32'(got.dy));
            cmp_field("cursor_x", 32'(want.cx), 32'(got.cx));
            cmp_field("cursor_y", 32'(want.cy), 32'(got.cy));
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [BYTE_W-1:0]          i_mouse_byte;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic                       o_packet_done;
    logic                       o_device_ready;
    logic [BTN_W-1:0]           o_buttons;
    logic signed [DX_W-1:0]     o_delta_x;
    logic signed [DY_W-1:0]     o_delta_y;
    logic [COORD_W-1:0]         o_cursor_x;
    logic [COORD_W-1:0]         o_cursor_y;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [PADDR_W-1:0]         paddr;
    logic [PDATA_W-1:0]         pwdata;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    tracker_scoreboard sb = new();
    bit hold_req = 1'b0;
    int cycle_count = 0;

    ps2_mouse_packet_cursor_tracker dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mouse_byte   (i_mouse_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_packet_done  (o_packet_done),
        .o_device_ready (o_device_ready),
        .o_buttons      (o_buttons),
        .o_delta_x      (o_delta_x),
        .o_delta_y      (o_delta_y),
        .o_cursor_x     (o_cursor_x),
        .o_cursor_y     (o_cursor_y),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a run that hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ps2_mouse_packet_cursor_tracker: mismatch");
            $finish;
        end
    end

    // Watch both channels at each edge.
    always @(posedge i_clk) begin
        tracker_result_t got;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_byte(i_mouse_byte);
            if (o_out_valid && i_out_ready) begin
                got.done = o_packet_done;
                got.dev_ready = o_device_ready;
                got.btn = o_buttons;
                got.dx = o_delta_x;
                got.dy = o_delta_y;
                got.cx = o_cursor_x;
                got.cy = o_cursor_y;
                sb.check_result(got);
            end
        end
    end

    // The receiver switches between stall patterns, and holds off for a long
    // stretch when asked to.
    initial begin
        rx_mode_e mode;
        int mode_left;
        int hold_left;
        mode = RX_STREAM;
        mode_left = 0;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = rx_mode_e'($urandom_range(0, 2));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    RX_STREAM: begin
                        i_out_ready <= 1'b1;
                    end
                    RX_RANDOM: begin
                        i_out_ready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        i_out_ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    // Offers one request and returns once it has been taken.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        i_in_valid <= 1'b1;
        i_mouse_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic sender_gap(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Sends a byte stream in bursts of random length with random gaps.
    task automatic send_stream(input byte_q_t bytes);
        int idx;
        int burst;
        idx = 0;
        while (idx < bytes.size()) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && idx < bytes.size()) begin
                send_byte(bytes[idx]);
                idx++;
                burst--;
            end
            if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 12));
        end
        sender_gap(1);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [COORD_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {{(PDATA_W-COORD_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_screen(idx, value);
    endtask

    // Mostly well-formed packets with random content, mixed with stray bytes.
    function automatic byte_q_t build_traffic(int n);
        byte_q_t q;
        logic [BYTE_W-1:0] fb;
        int pick;
        while (q.size() < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                fb = BYTE_W'($urandom);
                fb = (fb & ~SYNC_MASK) | SYNC_VALUE;
                q.push_back(fb);
                if (pick < 10) begin
                    q.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
                    q.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
                end else begin
                    q.push_back(BYTE_W'($urandom));
                    q.push_back(BYTE_W'($urandom));
                end
            end else if (pick < 88) begin
                q.push_back(ACK_BYTE);
            end else begin
                q.push_back(BYTE_W'($urandom));
            end
        end
        return q;
    endfunction

    task automatic run_phase(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
                             input bit hold_rx, input bit mid_pause);
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
        if (hold_rx) hold_req = 1'b1;
        if (mid_pause) begin
            send_stream(build_traffic(PHASE_ITEMS / 2));
            wait_drained();
            send_stream(build_traffic(PHASE_ITEMS / 2));
        end else begin
            send_stream(build_traffic(PHASE_ITEMS));
        end
        wait_drained();
    endtask

    initial begin
        byte_q_t directed_bytes;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_mouse_byte <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bytes before the acknowledge, bad first bytes, and packets with
        // the extreme movements and all buttons pressed.
        directed_bytes = '{8'h00, 8'hFF, 8'h08, 8'hFB, ACK_BYTE,
                           ACK_BYTE, 8'h88, 8'h48, 8'h00,
                           8'h0F, 8'hFF, 8'h00,
                           8'h38, 8'h00, 8'h00,
                           8'h08, 8'h00, 8'hFF,
                           8'h28, 8'h01, 8'h01,
                           8'h1B, 8'h80, 8'h7F};
        send_stream(directed_bytes);
        wait_drained();

        // Screen sizes at both extremes, mixed, and random.
        run_phase(12'd8, 12'd4, 1'b0, 1'b0);
        run_phase(12'd4095, 12'd4095, 1'b0, 1'b1);
        run_phase(12'd640, 12'd480, 1'b1, 1'b0);
        run_phase(12'd8, 12'd4095, 1'b0, 1'b0);
        run_phase(12'd4095, 12'd4, 1'b0, 1'b0);
        run_phase(COORD_W'($urandom_range(8, 4095)), COORD_W'($urandom_range(4, 4095)),
                  1'b0, 1'b0);
        run_phase(COORD_W'($urandom_range(8, 64)), COORD_W'($urandom_range(4, 64)),
                  1'b0, 1'b0);
        run_phase(WIDTH_RST, HEIGHT_RST, 1'b0, 1'b0);

        if (sb.n_fail == 0) begin
            $display("ps2_mouse_packet_cursor_tracker: match");
        end else begin
            $display("ps2_mouse_packet_cursor_tracker: mismatch");
        end
        $finish;
    end

endmodule

>>> ps2_mouse_packet_cursor_tracker.f
design/ps2mct_pkg.sv
design/ps2_mouse_packet_cursor_tracker.sv
design/ps2mct_checker.sv
dv/ps2_mouse_packet_cursor_tracker_test.sv
